@@ src/b64e_pkg.sv @@
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character map of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned SEXTET_W    = 6;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3d;

	// Number of '=' characters that close a group.
	typedef enum logic [1:0] {
		PAD_NONE = 2'd0,
		PAD_ONE  = 2'd1,
		PAD_TWO  = 2'd2
	} pad_t;

	// Bytes already held in the current group.
	typedef enum logic [1:0] {
		POS_0 = 2'd0,
		POS_1 = 2'd1,
		POS_2 = 2'd2
	} pos_t;

	// One group handed from front to back: three bytes (missing ones zero),
	// the padding it ends with and the end-of-message mark.
	typedef struct packed {
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
		logic [BYTE_W-1:0] b2;
		pad_t              pad;
		logic              fin;
	} group_t;

	typedef struct packed {
		logic   valid;
		group_t grp;
	} push_t;

	// Map a 6-bit index onto the standard alphabet.
	function automatic logic [BYTE_W-1:0] b64_char(input logic [SEXTET_W-1:0] idx);
		logic [BYTE_W-1:0] v;
		v = {2'b00, idx};
		if (idx < 6'd26) begin
			b64_char = 8'h41 + v;
		end else if (idx < 6'd52) begin
			b64_char = 8'h61 + v - 8'd26;
		end else if (idx < 6'd62) begin
			b64_char = 8'h30 + v - 8'd52;
		end else if (idx == 6'd62) begin
			b64_char = 8'h2b;
		end else begin
			b64_char = 8'h2f;
		end
	endfunction

endpackage

@@ src/b64e_front.sv @@
// ----------------------------------------------------------------------------
// b64e_front
// Collects input bytes into groups of three and hands closed groups on.
// ----------------------------------------------------------------------------
module b64e_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [b64e_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          final_byte,
	output b64e_pkg::push_t               push
);
	import b64e_pkg::*;

	logic [BYTE_W-1:0] held0_q;
	logic [BYTE_W-1:0] held1_q;
	pos_t              pos_q;
	pos_t              pos_d;

	always_comb begin
		push.valid   = 1'b0;
		push.grp.b0  = held0_q;
		push.grp.b1  = held1_q;
		push.grp.b2  = data_byte;
		push.grp.pad = PAD_NONE;
		push.grp.fin = final_byte;
		pos_d        = pos_q;
		case (pos_q)
			POS_1: begin
				if (accept) begin
					if (final_byte) begin
						push.valid   = 1'b1;
						push.grp.b1  = data_byte;
						push.grp.b2  = '0;
						push.grp.pad = PAD_ONE;
						pos_d        = POS_0;
					end else begin
						pos_d = POS_2;
					end
				end
			end
			POS_2: begin
				if (accept) begin
					push.valid = 1'b1;
					pos_d      = POS_0;
				end
			end
			default: begin
				// a stray position restarts the group
				if (accept) begin
					if (final_byte) begin
						push.valid   = 1'b1;
						push.grp.b0  = data_byte;
						push.grp.b1  = '0;
						push.grp.b2  = '0;
						push.grp.pad = PAD_TWO;
						pos_d        = POS_0;
					end else begin
						pos_d = POS_1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_0;
		end else begin
			pos_q <= pos_d;
		end
	end

	// hold the first two bytes of the group
	always_ff @(posedge clk) begin
		if (accept && pos_q == POS_1) begin
			held1_q <= data_byte;
		end else if (accept && pos_q != POS_2) begin
			held0_q <= data_byte;
		end
	end

endmodule

@@ src/b64e_queue.sv @@
// ----------------------------------------------------------------------------
// b64e_queue
// Short register queue of closed groups between front and back.
// ----------------------------------------------------------------------------
module b64e_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  b64e_pkg::push_t   push,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output b64e_pkg::group_t  head
);
	import b64e_pkg::*;

	group_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			next_ptr = '0;
		end else begin
			next_ptr = p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.grp;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("group pushed into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");

endmodule

@@ src/b64e_back.sv @@
// ----------------------------------------------------------------------------
// b64e_back
// Expands a group into four characters, one per cycle in an output register unless stalled.
// ----------------------------------------------------------------------------
module b64e_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          empty,
	input  b64e_pkg::group_t              head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [b64e_pkg::BYTE_W-1:0]   out_char,
	output logic                          last_char
);
	import b64e_pkg::*;

	group_t            grp_q;
	logic              busy_q;
	logic [1:0]        idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_char_q;
	logic              last_q;
	logic              load;
	logic              done;
	logic [SEXTET_W-1:0] sextet;
	logic              is_pad;
	logic [BYTE_W-1:0] next_char;

	assign load = busy_q && (!out_valid_q || out_ready);
	assign done = load && (idx_q == 2'd3);
	assign pop  = !empty && (!busy_q || done);

	always_comb begin
		case (idx_q)
			2'd0:    sextet = grp_q.b0[7:2];
			2'd1:    sextet = {grp_q.b0[1:0], grp_q.b1[7:4]};
			2'd2:    sextet = {grp_q.b1[3:0], grp_q.b2[7:6]};
			default: sextet = grp_q.b2[5:0];
		endcase
		case (grp_q.pad)
			PAD_ONE: is_pad = (idx_q == 2'd3);
			PAD_TWO: is_pad = (idx_q == 2'd2) || (idx_q == 2'd3);
			default: is_pad = 1'b0;
		endcase
		next_char = is_pad ? PAD_CHAR : b64_char(sextet);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else begin
				if (done) begin
					busy_q <= 1'b0;
				end
				if (load) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head;
		end
		if (load) begin
			out_char_q <= next_char;
			last_q     <= grp_q.fin && (idx_q == 2'd3);
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(out_char) && $stable(last_char)))
		else $error("output register overwritten while stalled");

	a_last_on_fourth: assert property (@(posedge clk) disable iff (!arst_n)
		(load && idx_q != 2'd3) |=> !last_q)
		else $error("last mark on a character before the fourth");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && busy_q) |-> done)
		else $error("group taken while the previous one is unfinished");

endmodule

@@ src/base64_stream_encoder.sv @@
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Byte stream in, base64 characters out, padding and end mark on the last group.
// ----------------------------------------------------------------------------
// A closing byte writes its group into the queue; the back then loads it into
//   its group register and sends each character out through the output register.
// Throughput: one byte per cycle in while the group queue has room; four
//   characters per group out, one per cycle through the single output register
//   while m_tready does not stall it.
// Reset: arst_n clears group position, queue pointers and all valid flags.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
	input  logic       clk,
	input  logic       arst_n,
	// input bytes
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // final_byte
	// output characters
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_char
	output logic       m_tlast    // last_char
);
	import b64e_pkg::*;

	push_t  push;
	group_t head;
	logic   q_full;
	logic   q_empty;
	logic   q_pop;
	logic   s_accept;

	// Take a byte whenever the queue can absorb a closed group; a byte that
	// only gets held would fit anyway, but one rule keeps the ready path short.
	assign s_tready = !q_full;
	assign s_accept = s_tvalid && s_tready;

	// Front: hold bytes, track the group position, close groups.
	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (s_accept),
		.data_byte  (s_tdata),
		.final_byte (s_tlast),
		.push       (push)
	);

	// Decouple the byte side from the character side.
	b64e_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.head   (head)
	);

	// Back: advance through the four characters of each group.
	b64e_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (q_empty),
		.head      (head),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.last_char (m_tlast)
	);

endmodule
